// ===== src/lhc_pkg.sv =====
`default_nettype none

package lhc_pkg;

  // Byte codes that steer the scanner
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // Token classes
  localparam logic [2:0] CLS_PLAIN   = 3'd0;
  localparam logic [2:0] CLS_COMMENT = 3'd1;
  localparam logic [2:0] CLS_KEYWORD = 3'd2;
  localparam logic [2:0] CLS_MATH    = 3'd3;
  localparam logic [2:0] CLS_MARKUP  = 3'd4;

  // Scanner mode, one-hot
  typedef enum logic [9:0] {
    MODE_NORMAL      = 10'b00_0000_0001,
    MODE_COMMENT     = 10'b00_0000_0010,
    MODE_CMD_FIRST   = 10'b00_0000_0100,
    MODE_CMD_WORD    = 10'b00_0000_1000,
    MODE_MATH_OPEN   = 10'b00_0001_0000,
    MODE_INLINE      = 10'b00_0010_0000,
    MODE_INLINE_ESC  = 10'b00_0100_0000,
    MODE_DISPLAY     = 10'b00_1000_0000,
    MODE_DISPLAY_ESC = 10'b01_0000_0000,
    MODE_DCLOSE      = 10'b10_0000_0000
  } mode_t;

  // Classification of one byte
  typedef struct packed {
    logic [2:0] token_class;
    logic       token_begins;
  } tok_res_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

// ===== src/lhc_stream_if.sv =====
`default_nettype none

// Input byte channel
interface lhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// Result channel
interface lhc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_class;
  logic       token_begins;

  modport source (output valid, output token_class, output token_begins, input ready);
  modport sink   (input valid, input token_class, input token_begins, output ready);
endinterface

`default_nettype wire

// ===== src/lhc_classify.sv =====
`default_nettype none

module lhc_classify (
  input  wire lhc_pkg::mode_t mode_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           final_i,
  output lhc_pkg::mode_t      mode_nxt_o,
  output lhc_pkg::tok_res_t   res_o
);
  import lhc_pkg::*;

  mode_t    norm_mode;
  tok_res_t norm_res;
  mode_t    step_mode;

  // Classify the byte as if it arrived in normal mode
  always_comb begin
    norm_res.token_begins = 1'b1;
    norm_mode             = MODE_NORMAL;
    if (byte_i == CH_PERCENT) begin
      norm_res.token_class = CLS_COMMENT;
      norm_mode            = MODE_COMMENT;
    end else if (byte_i == CH_BACKSLASH) begin
      norm_res.token_class = CLS_KEYWORD;
      norm_mode            = MODE_CMD_FIRST;
    end else if (byte_i == CH_DOLLAR) begin
      norm_res.token_class = CLS_MATH;
      norm_mode            = MODE_MATH_OPEN;
    end else if ((byte_i == CH_LBRACE) || (byte_i == CH_RBRACE) || (byte_i == CH_AMP)) begin
      norm_res.token_class = CLS_MARKUP;
    end else begin
      norm_res.token_class  = CLS_PLAIN;
      norm_res.token_begins = 1'b0;
    end
  end

  // Advance the scanner by one byte
  always_comb begin
    res_o     = '{token_class: CLS_MATH, token_begins: 1'b0};
    step_mode = mode_i;
    unique case (mode_i)
      MODE_COMMENT: begin
        if (byte_i == CH_NEWLINE) begin
          res_o     = norm_res;
          step_mode = norm_mode;
        end else begin
          res_o.token_class = CLS_COMMENT;
        end
      end
      MODE_CMD_FIRST: begin
        res_o.token_class = CLS_KEYWORD;
        step_mode         = is_letter(byte_i) ? MODE_CMD_WORD : MODE_NORMAL;
      end
      MODE_CMD_WORD: begin
        if (is_letter(byte_i)) begin
          res_o.token_class = CLS_KEYWORD;
        end else if (byte_i == CH_STAR) begin
          res_o.token_class = CLS_KEYWORD;
          step_mode         = MODE_NORMAL;
        end else begin
          res_o     = norm_res;
          step_mode = norm_mode;
        end
      end
      MODE_MATH_OPEN: begin
        if (byte_i == CH_DOLLAR)         step_mode = MODE_DISPLAY;
        else if (byte_i == CH_BACKSLASH) step_mode = MODE_INLINE_ESC;
        else                             step_mode = MODE_INLINE;
      end
      MODE_INLINE: begin
        if (byte_i == CH_BACKSLASH)   step_mode = MODE_INLINE_ESC;
        else if (byte_i == CH_DOLLAR) step_mode = MODE_NORMAL;
      end
      MODE_INLINE_ESC: begin
        step_mode = MODE_INLINE;
      end
      MODE_DISPLAY: begin
        if (byte_i == CH_BACKSLASH)   step_mode = MODE_DISPLAY_ESC;
        else if (byte_i == CH_DOLLAR) step_mode = MODE_DCLOSE;
      end
      MODE_DISPLAY_ESC: begin
        step_mode = MODE_DISPLAY;
      end
      MODE_DCLOSE: begin
        if (byte_i == CH_DOLLAR) begin
          step_mode = MODE_NORMAL;
        end else begin
          res_o     = norm_res;
          step_mode = norm_mode;
        end
      end
      default: begin
        res_o     = norm_res;
        step_mode = norm_mode;
      end
    endcase
  end

  // Drop back to normal mode after the last byte of a text
  assign mode_nxt_o = final_i ? MODE_NORMAL : step_mode;

endmodule

`default_nettype wire

// ===== src/latex_highlight_classifier_unit.sv =====
`default_nettype none

// Path: the input register captures each input transaction, then the result register holds its
// classification until the result transaction.
// Throughput: one byte per cycle unless out_ch.ready blocks the output; the scan mode register
// updates as a byte moves from the input register into the result register.
// Reset (rst_n low, synchronous): both pipeline stages empty, scan mode normal.

module latex_highlight_classifier_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lhc_in_if.sink     in_ch,
  lhc_out_if.source  out_ch
);
  import lhc_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_final_r;
  logic       out_valid_r, out_valid_nxt;
  tok_res_t   out_res_r;
  mode_t      mode_r, mode_nxt;
  tok_res_t   cls_res;
  logic       s1_adv;
  logic       in_take;

  // Stage handshakes: the result register frees the input stage
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  lhc_classify u_classify (
    .mode_i     (mode_r),
    .byte_i     (s1_byte_r),
    .final_i    (s1_final_r),
    .mode_nxt_o (mode_nxt),
    .res_o      (cls_res)
  );

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_NORMAL;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        mode_r <= mode_nxt;
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_ch.text_byte;
      s1_final_r <= in_ch.final_byte;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= cls_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_class  = out_res_r.token_class;
  assign out_ch.token_begins = out_res_r.token_begins;

  // The last byte of a text always leaves the scanner in normal mode
  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_final_r) |=> (mode_r == MODE_NORMAL))
    else $error("scan mode not normal after last byte");

  // Plain bytes never open a token
  a_plain_no_begin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.token_class == CLS_PLAIN)) |-> !out_res_r.token_begins)
    else $error("plain byte marked as token start");

  // Input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without backpressure");

  // A stage-one item moving out always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item lost");

  // Class codes stay within the defined set
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.token_class <= CLS_MARKUP))
    else $error("token class out of range");

endmodule

`default_nettype wire
